FILE: design/p2a_pkg.sv
// Shared types, format codes and conversion constants for the pixel to ARGB converter.
`default_nettype none
package p2a_pkg;

	// Pixel format codes held in the format register
	localparam logic [2:0] FMT_YCC    = 3'd0;
	localparam logic [2:0] FMT_LUMA   = 3'd1;
	localparam logic [2:0] FMT_RGB    = 3'd2;
	localparam logic [2:0] FMT_GREY   = 3'd3;
	localparam logic [2:0] FMT_GREY_A = 3'd4;
	localparam logic [2:0] FMT_RGBA   = 3'd5;
	localparam logic [2:0] FMT_RESET  = FMT_RGB;

	// Q16 colour conversion coefficients
	localparam logic [16:0] COEF_CR_R = 17'd91881;
	localparam logic [16:0] COEF_CB_G = 17'd22554;
	localparam logic [16:0] COEF_CR_G = 17'd46802;
	localparam logic [16:0] COEF_CB_B = 17'd116130;

	localparam logic [7:0] CHROMA_MID = 8'd128;
	localparam logic [7:0] CHAN_MAX   = 8'd255;

	// Product and sum widths for the Q16 arithmetic
	localparam int PROD_W = 26;
	localparam int SUM_W  = 27;

	// Queue between front and back
	localparam int QUEUE_AW    = 1;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	// Classified word: for YCbCr the bytes are Y, Cb, Cr; otherwise final R, G, B.
	typedef struct packed {
		logic       is_ycc;
		logic [7:0] alpha;
		logic [7:0] ch_a;
		logic [7:0] ch_b;
		logic [7:0] ch_c;
	} item_t;

	// Floor to an integer channel and saturate to 0..255.
	function automatic logic [7:0] sat_q16(input logic signed [SUM_W-1:0] v);
		logic [7:0] res;
		if (v[SUM_W-1]) begin
			res = 8'd0;
		end else if (|v[SUM_W-2:24]) begin
			res = CHAN_MAX;
		end else begin
			res = v[23:16];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

FILE: design/p2a_front.sv
// Front part: accepts pixels and classifies them by the configured format.
`default_nettype none
module p2a_front
	import p2a_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [2:0] fmt,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] comp_a,
	input  wire logic [7:0] comp_b,
	input  wire logic [7:0] comp_c,
	input  wire logic [7:0] alpha_in,
	output logic            item_valid,
	input  wire logic       item_ready,
	output item_t           item
);

	logic  vld_s1;
	item_t item_s1;
	item_t cls;
	logic  take;

	always_comb begin
		cls        = '0;
		cls.is_ycc = 1'b0;
		case (fmt)
			FMT_YCC: begin
				cls.is_ycc = 1'b1;
				cls.ch_a   = comp_a;
				cls.ch_b   = comp_b;
				cls.ch_c   = comp_c;
			end
			FMT_LUMA, FMT_GREY: begin
				cls.ch_a = comp_a;
				cls.ch_b = comp_a;
				cls.ch_c = comp_a;
			end
			FMT_RGB: begin
				cls.ch_a = comp_a;
				cls.ch_b = comp_b;
				cls.ch_c = comp_c;
			end
			FMT_GREY_A: begin
				cls.alpha = CHAN_MAX - alpha_in;
				cls.ch_a  = comp_a;
				cls.ch_b  = comp_a;
				cls.ch_c  = comp_a;
			end
			FMT_RGBA: begin
				cls.alpha = CHAN_MAX - alpha_in;
				cls.ch_a  = comp_a;
				cls.ch_b  = comp_b;
				cls.ch_c  = comp_c;
			end
			default: begin
				cls = '0;
			end
		endcase
	end

	assign take     = !vld_s1 || item_ready;
	assign in_stall = !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			item_s1 <= cls;
		end
	end

	assign item_valid = vld_s1;
	assign item       = item_s1;

endmodule
`default_nettype wire

FILE: design/p2a_queue.sv
// Short queue of classified words between the front and the back part.
`default_nettype none
module p2a_queue
	import p2a_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire item_t push_item,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output item_t      pop_item
);

	item_t                 entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

FILE: design/p2a_back.sv
// Back part: YCbCr colour products, saturation and ARGB packing into the output register.
`default_nettype none
module p2a_back
	import p2a_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_ready,
	input  wire item_t item,
	output logic       out_valid,
	input  wire logic  out_stall,
	output logic [31:0] argb_word
);

	logic                     vld_s1;
	item_t                    item_s1;
	logic signed [PROD_W-1:0] pr_s1;
	logic signed [PROD_W-1:0] pgb_s1;
	logic signed [PROD_W-1:0] pgr_s1;
	logic signed [PROD_W-1:0] pb_s1;
	logic                     vld_s2;
	logic [31:0]              argb_s2;

	logic                     ready_s1;
	logic                     ready_s2;
	logic signed [8:0]        db;
	logic signed [8:0]        dr;
	logic signed [PROD_W-1:0] db_ext;
	logic signed [PROD_W-1:0] dr_ext;
	logic signed [SUM_W-1:0]  y16;
	logic signed [SUM_W-1:0]  r_sum;
	logic signed [SUM_W-1:0]  g_sum;
	logic signed [SUM_W-1:0]  b_sum;
	logic [31:0]              word;

	assign ready_s2   = !vld_s2 || !out_stall;
	assign ready_s1   = !vld_s1 || ready_s2;
	assign item_ready = ready_s1;

	// Chroma offsets around the mid value, sign-extended for the products.
	assign db     = $signed({1'b0, item.ch_b}) - $signed({1'b0, CHROMA_MID});
	assign dr     = $signed({1'b0, item.ch_c}) - $signed({1'b0, CHROMA_MID});
	assign db_ext = PROD_W'(db);
	assign dr_ext = PROD_W'(dr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				vld_s1 <= item_valid;
			end
			if (ready_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && item_valid) begin
			item_s1 <= item;
			pr_s1   <= dr_ext * $signed(PROD_W'(COEF_CR_R));
			pgb_s1  <= db_ext * $signed(PROD_W'(COEF_CB_G));
			pgr_s1  <= dr_ext * $signed(PROD_W'(COEF_CR_G));
			pb_s1   <= db_ext * $signed(PROD_W'(COEF_CB_B));
		end
	end

	assign y16   = $signed({{(SUM_W-24){1'b0}}, item_s1.ch_a, 16'h0000});
	assign r_sum = y16 + SUM_W'(pr_s1);
	assign g_sum = y16 - SUM_W'(pgb_s1) - SUM_W'(pgr_s1);
	assign b_sum = y16 + SUM_W'(pb_s1);

	always_comb begin
		if (item_s1.is_ycc) begin
			word = {8'h00, sat_q16(r_sum), sat_q16(g_sum), sat_q16(b_sum)};
		end else begin
			word = {item_s1.alpha, item_s1.ch_a, item_s1.ch_b, item_s1.ch_c};
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && vld_s1) begin
			argb_s2 <= word;
		end
	end

	assign out_valid = vld_s2;
	assign argb_word = argb_s2;

endmodule
`default_nettype wire

FILE: design/pixel_to_argb_converter_top.sv
// Top level of the pixel to ARGB converter: format register, front, queue and back.
// The converter takes one pixel word per clock while in_stall is low and delivers one
// packed ARGB word per clock while out_stall is low. Words arrive in order and the
// throughput is set by the two-stage back pipeline (colour products, then sum and saturate),
// which advances every cycle while the output is not stalled. A two-entry queue decouples
// the classifying front from the back, and the output word sits in a register of its own.
// The pixel format register resets to RGB and must only be written while the converter is
// empty; formats six and seven produce an all-zero word.
`default_nettype none
module pixel_to_argb_converter_top
	import p2a_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] comp_a,
	input  wire logic [7:0] comp_b,
	input  wire logic [7:0] comp_c,
	input  wire logic [7:0] alpha_in,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [31:0]     argb_word
);

	logic [2:0] pixel_format_q;
	logic       fr_valid;
	logic       fr_ready;
	item_t      fr_item;
	logic       bk_valid;
	logic       bk_ready;
	item_t      bk_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= FMT_RESET;
		end else if (cfg_we) begin
			pixel_format_q <= cfg_wdata;
		end
	end

	p2a_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.fmt        (pixel_format_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.comp_a     (comp_a),
		.comp_b     (comp_b),
		.comp_c     (comp_c),
		.alpha_in   (alpha_in),
		.item_valid (fr_valid),
		.item_ready (fr_ready),
		.item       (fr_item)
	);

	p2a_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_item  (fr_item),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_item   (bk_item)
	);

	p2a_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (bk_valid),
		.item_ready (bk_ready),
		.item       (bk_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.argb_word  (argb_word)
	);

endmodule
`default_nettype wire

FILE: tb/sv/pixel_to_argb_converter_top_tb.sv
// Self-checking testbench for the pixel to ARGB converter, with its own conversion predictor.
`default_nettype none
module pixel_to_argb_converter_top_tb;
	import p2a_pkg::*;

	// Format codes with no defined conversion; the converter must give an all-zero word.
	localparam logic [2:0] FMT_SPARE_6 = 3'd6;
	localparam logic [2:0] FMT_SPARE_7 = 3'd7;

	// Q16 multipliers for full-range YCbCr to RGB
	localparam int MUL_CR_TO_R = 91881;
	localparam int MUL_CB_TO_G = 22554;
	localparam int MUL_CR_TO_G = 46802;
	localparam int MUL_CB_TO_B = 116130;
	localparam int CHROMA_ZERO = 128;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 8;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  comp_a;
	logic [7:0]  comp_b;
	logic [7:0]  comp_c;
	logic [7:0]  alpha_in;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] argb_word;

	logic [31:0] argb_expected[$];
	logic [31:0] argb_want;
	logic [2:0]  cur_fmt;
	logic        tx_gaps;
	logic        rx_gaps;
	int          hold_request;
	int          err_count;
	int          pixels_sent;
	int          words_checked;
	int          cfg_writes;
	int          in_stall_cycles;
	int          quiet_cycles;
	int          fmt_hits[8];

	pixel_to_argb_converter_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.comp_a    (comp_a),
		.comp_b    (comp_b),
		.comp_c    (comp_c),
		.alpha_in  (alpha_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.argb_word (argb_word)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] clamp_q16(input int v);
		int whole;
		if (v < 0) begin
			return 8'h00;
		end
		whole = v >>> 16;
		if (whole > 255) begin
			return 8'hFF;
		end
		return whole[7:0];
	endfunction

	function automatic logic [31:0] expected_argb(input logic [2:0] fmt, input logic [7:0] a,
		input logic [7:0] b, input logic [7:0] c, input logic [7:0] al);
		int         luma16;
		int         d_cb;
		int         d_cr;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] inv_alpha;
		luma16    = int'(a) * 65536;
		d_cb      = int'(b) - CHROMA_ZERO;
		d_cr      = int'(c) - CHROMA_ZERO;
		inv_alpha = 8'hFF - al;
		case (fmt)
			FMT_YCC: begin
				red   = clamp_q16(luma16 + MUL_CR_TO_R * d_cr);
				green = clamp_q16(luma16 - MUL_CB_TO_G * d_cb - MUL_CR_TO_G * d_cr);
				blue  = clamp_q16(luma16 + MUL_CB_TO_B * d_cb);
				return {8'h00, red, green, blue};
			end
			FMT_LUMA, FMT_GREY: return {8'h00, a, a, a};
			FMT_RGB:            return {8'h00, a, b, c};
			FMT_GREY_A:         return {inv_alpha, a, a, a};
			FMT_RGBA:           return {inv_alpha, a, b, c};
			default:            return 32'h0000_0000;
		endcase
	endfunction

	// Leans towards the byte extremes and the chroma midpoint, where saturation bites.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		$display("mismatch on %s: expected %08h, got %08h (format %0d)", what, want, got, cur_fmt);
		err_count++;
	endtask

	// Offers one pixel word and waits until the converter takes it.
	task automatic send_pixel(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
		input logic [7:0] al);
		@(negedge clk);
		if (tx_gaps && $urandom_range(0, 7) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid = 1'b1;
		comp_a   = a;
		comp_b   = b;
		comp_c   = c;
		alpha_in = al;
		@(posedge clk);
		while (in_stall) begin
			in_stall_cycles++;
			@(posedge clk);
		end
		argb_expected.push_back(expected_argb(cur_fmt, a, b, c, al));
		fmt_hits[cur_fmt]++;
		pixels_sent++;
	endtask

	task automatic send_random_pixel();
		send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
	endtask

	// The format register may only change once every word in flight has come out.
	task automatic set_format(input logic [2:0] fmt);
		@(negedge clk);
		in_valid = 1'b0;
		while (argb_expected.size() != 0) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = fmt;
		@(negedge clk);
		cfg_we  = 1'b0;
		cur_fmt = fmt;
		cfg_writes++;
	endtask

	task automatic test_reset_format();
		send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h55, 8'hAA, 8'h5A, 8'hA5);
	endtask

	task automatic test_ycc_corners();
		set_format(FMT_YCC);
		send_pixel(8'h00, 8'h80, 8'h80, 8'h00);
		send_pixel(8'hFF, 8'h80, 8'h80, 8'hFF);
		send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
		send_pixel(8'h00, 8'hFF, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'h00, 8'hFF, 8'hFF);
		send_pixel(8'h80, 8'hFF, 8'h00, 8'h00);
		send_pixel(8'h80, 8'h00, 8'hFF, 8'h00);
	endtask

	// The b and c components carry random values, which must not reach the word in the grey formats.
	task automatic test_copy_formats();
		logic [2:0] fmts[4];
		fmts = '{FMT_LUMA, FMT_GREY, FMT_GREY_A, FMT_RGBA};
		foreach (fmts[i]) begin
			set_format(fmts[i]);
			send_pixel(8'h00, pick_byte(), pick_byte(), 8'h00);
			send_pixel(8'hFF, pick_byte(), pick_byte(), 8'hFF);
		end
	endtask

	task automatic test_spare_formats();
		set_format(FMT_SPARE_6);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
		send_random_pixel();
		set_format(FMT_SPARE_7);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_random_pixel();
	endtask

	task automatic test_random_phases();
		logic [2:0] fmt;
		int         count;
		for (int phase = 0; phase < 20; phase++) begin
			if (phase < 8) begin
				fmt = 3'(phase);
			end else if ($urandom_range(0, 9) == 0) begin
				fmt = 3'($urandom_range(6, 7));
			end else begin
				fmt = 3'($urandom_range(0, 5));
			end
			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_gaps = ($urandom_range(0, 3) != 0);
			set_format(fmt);
			count = $urandom_range(40, 100);
			repeat (count) send_random_pixel();
		end
	endtask

	// The receiver holds off for a long stretch while words keep coming, so the
	// queue fills and the converter has to stall its input.
	task automatic test_backpressure();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		set_format(FMT_YCC);
		@(posedge clk);
		hold_request = HOLD_CYCLES;
		repeat (40) send_random_pixel();
	endtask

	task automatic test_full_rate();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		set_format(FMT_RGBA);
		repeat (80) send_random_pixel();
		set_format(FMT_YCC);
		repeat (80) send_random_pixel();
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = FMT_RESET;
		in_valid        = 1'b0;
		comp_a          = 8'h00;
		comp_b          = 8'h00;
		comp_c          = 8'h00;
		alpha_in        = 8'h00;
		cur_fmt         = FMT_RESET;
		tx_gaps         = 1'b1;
		rx_gaps         = 1'b1;
		hold_request    = 0;
		err_count       = 0;
		pixels_sent     = 0;
		words_checked   = 0;
		cfg_writes      = 0;
		in_stall_cycles = 0;
		foreach (fmt_hits[i]) fmt_hits[i] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_format();
		test_ycc_corners();
		test_copy_formats();
		test_spare_formats();
		test_random_phases();
		test_backpressure();
		test_full_rate();

		@(negedge clk);
		in_valid = 1'b0;
		while (argb_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d pixels and %0d words checked over %0d format writes, %0d stalled input cycles",
			pixels_sent, words_checked, cfg_writes, in_stall_cycles);
		$display("pixels per format 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", fmt_hits[0], fmt_hits[1],
			fmt_hits[2], fmt_hits[3], fmt_hits[4], fmt_hits[5], fmt_hits[6], fmt_hits[7]);
		if (err_count == 0) begin
			$display("pixel_to_argb_converter_top_tb: PASS");
		end else begin
			$display("pixel_to_argb_converter_top_tb: FAIL");
		end
		$finish;
	end

	// Receiver: random stall bursts, or one long hold when the back-pressure test asks.
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end else if (stall_left == 0 && rx_gaps && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 17);
			end
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (argb_expected.size() == 0) begin
				report_mismatch("word with no pixel pending", 32'h0000_0000, argb_word);
			end else begin
				argb_want = argb_expected.pop_front();
				if (argb_word !== argb_want) begin
					report_mismatch("argb_word", argb_want, argb_word);
				end
				words_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("pixel_to_argb_converter_top_tb: FAIL");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule
`default_nettype wire
